>>> rtl/core/pgd_pkg.sv
// Package with types, constants and helpers for the particle grid deposit block.
package pgd_pkg;
  localparam int GRID_SIDE     = 64;
  localparam int POS_FRAC_BITS = 16;
  localparam int VEL_FRAC_BITS = 12;
  localparam int ACC_WIDTH     = 48;
  localparam int SIDE_BITS     = $clog2(GRID_SIDE);
  localparam int ADDR_BITS     = 3 * SIDE_BITS;
  localparam int CELLS         = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] REG_CELL_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_VEL_ENABLE  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DISPERSION  = 2'd2;

  localparam logic REQ_DEPOSIT = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [21:0]        pos_x;
    logic [21:0]        pos_y;
    logic [21:0]        pos_z;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] vel_z;
    logic [17:0]        cell_index;
  } in_item_t;

  typedef struct packed {
    logic [47:0]        density_sum;
    logic signed [47:0] vel_x_sum;
    logic signed [47:0] vel_y_sum;
    logic signed [47:0] vel_z_sum;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_FIN,
    ST_RD, ST_ACC, ST_WR, ST_RREAD, ST_RWAIT
  } state_t;

  typedef struct packed {
    logic [SIDE_BITS-1:0] base;
    logic                 two;
  } axis_t;

  function automatic axis_t axis_cells(input logic [21:0] p);
    axis_t a;
    logic [SIDE_BITS-1:0] ip;
    logic [POS_FRAC_BITS-1:0] fr;
    ip = p[POS_FRAC_BITS +: SIDE_BITS];
    fr = p[POS_FRAC_BITS-1:0];
    if (!fr[POS_FRAC_BITS-1]) begin
      a.base = ip - 1'b1;
      a.two  = 1'b1;
    end else begin
      a.base = ip;
      a.two  = (fr != {1'b1, {(POS_FRAC_BITS-1){1'b0}}});
    end
    return a;
  endfunction
endpackage

>>> rtl/core/pgd_vel_unit.sv
// Shared multiplier sequencer computing the three saturated velocity deposits.
module pgd_vel_unit import pgd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [31:0]                 weight,
  input  logic                        disp,
  input  logic signed [23:0]          vx,
  input  logic signed [23:0]          vy,
  input  logic signed [23:0]          vz,
  output logic                        done,
  output logic signed [ACC_WIDTH-1:0] dv [3]
);
  // One 32x24 multiply per cycle; dispersion needs a second 56x24 multiply done in
  // two 32x24 halves. Steps: per axis, (1) w*|v|, (2) lo*|vx|, (3) hi*|vx|, (4) finish.
  logic [1:0]  axis_r, axis_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic [55:0] prod_r;
  logic [55:0] plo_r;
  logic [80:0] full_w;
  logic [23:0] mag_v, mag_x;
  logic        neg_v, neg_x;
  logic signed [23:0] vsel;
  logic [31:0] ma;
  logic [23:0] mb;
  logic [55:0] mp;
  logic [80:0] mag;
  logic        neg;
  logic signed [ACC_WIDTH-1:0] res;
  localparam logic [80:0] SMAX = 81'((64'd1 << (ACC_WIDTH-1)) - 1);

  always_comb begin
    case (axis_r)
      2'd0:    vsel = vx;
      2'd1:    vsel = vy;
      default: vsel = vz;
    endcase
    neg_v = vsel[23];
    mag_v = neg_v ? 24'(-vsel) : vsel;
    neg_x = vx[23];
    mag_x = neg_x ? 24'(-vx) : vx;
    case (step_r)
      2'd0:    begin ma = weight;        mb = mag_v; end
      2'd1:    begin ma = prod_r[31:0];  mb = mag_x; end
      default: begin ma = 32'(prod_r[55:32]); mb = mag_x; end
    endcase
    mp = 56'(ma) * 56'(mb);
    full_w = 81'(plo_r) + {mp[48:0], 32'd0};
    if (disp) begin
      mag = full_w >> (2*VEL_FRAC_BITS);
      neg = neg_v ^ neg_x;
    end else begin
      mag = 81'(prod_r) >> VEL_FRAC_BITS;
      neg = neg_v;
    end
    if (mag > SMAX) res = neg ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : SMAX[ACC_WIDTH-1:0];
    else            res = neg ? -mag[ACC_WIDTH-1:0] : mag[ACC_WIDTH-1:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    axis_nxt = axis_r;
    step_nxt = step_r;
    done     = 1'b0;
    if (!busy_r) begin
      if (go) begin
        busy_nxt = 1'b1;
        axis_nxt = 2'd0;
        step_nxt = 2'd0;
      end
    end else if (step_r == 2'd0) begin
      step_nxt = disp ? 2'd1 : 2'd3;
    end else if (step_r != 2'd3) begin
      step_nxt = step_r + 2'd1;
    end else begin
      step_nxt = 2'd0;
      if (axis_r == 2'd2) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end else begin
        axis_nxt = axis_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      axis_r <= 2'd0;
      step_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      axis_r <= axis_nxt;
      step_r <= step_nxt;
    end
    if (busy_r) begin
      // The high partial product is recomputed and folded at the finish step.
      case (step_r)
        2'd0:    prod_r <= mp;
        2'd1:    plo_r  <= 56'(mp);
        2'd2:    plo_r  <= plo_r;
        default: dv[axis_r] <= res;
      endcase
    end
  end
endmodule

>>> rtl/core/particle_grid_deposit.sv
// Top level of the particle grid deposit block: sequencer and the four cell stores.
// One transaction at a time. A deposit runs the velocity multiplier (skipped with velocity
// off, longer with dispersion), then reads, accumulates and writes each covered cell.
// Reads hold busy in ST_RREAD and ST_RWAIT, out_valid in ST_RWAIT; deposits give no result.
// After reset a clearing pass writes zero to all 262144 cells, one per cycle, with
// busy high. The receiver cannot stall; each result is shown for exactly one cycle.
module particle_grid_deposit import pgd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  output out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);
  localparam logic [ACC_WIDTH-1:0] DMAX = '1;
  localparam logic signed [ACC_WIDTH-1:0] SMAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] SMIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  // Four parallel stores sharing one address per cycle.
  logic [ACC_WIDTH-1:0] mem_d [CELLS];
  logic [ACC_WIDTH-1:0] mem_x [CELLS];
  logic [ACC_WIDTH-1:0] mem_y [CELLS];
  logic [ACC_WIDTH-1:0] mem_z [CELLS];
  logic [ACC_WIDTH-1:0] rd_d_r, rd_x_r, rd_y_r, rd_z_r;
  logic [ACC_WIDTH-1:0] wd_d_r, wd_x_r, wd_y_r, wd_z_r;

  logic [31:0] weight_r;
  logic        vel_en_r, disp_r;

  state_t state_r, state_nxt;
  in_item_t item_r;
  axis_t ax_r, ay_r, az_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic [ADDR_BITS:0] clr_r, clr_nxt;
  logic [ADDR_BITS-1:0] addr;
  logic       oor_r;
  logic       vgo, vdone, last;
  logic signed [ACC_WIDTH-1:0] dv [3];
  logic accept;

  assign accept = start && !busy;

  pgd_vel_unit u_vel (
    .clk(clk), .rst_n(rst_n), .go(vgo), .weight(weight_r), .disp(disp_r),
    .vx(item_r.vel_x), .vy(item_r.vel_y), .vz(item_r.vel_z),
    .done(vdone), .dv(dv)
  );

  // Cell address: clear counter, read index or loop counter; z runs fastest, then y, then x.
  always_comb begin
    logic [SIDE_BITS-1:0] x, y, z;
    x = ax_r.base + SIDE_BITS'(cnt_r[2]);
    y = ay_r.base + SIDE_BITS'(cnt_r[1]);
    z = az_r.base + SIDE_BITS'(cnt_r[0]);
    if (state_r == ST_CLEAR)      addr = clr_r[ADDR_BITS-1:0];
    else if (state_r == ST_RREAD) addr = item_r.cell_index[ADDR_BITS-1:0];
    else                          addr = {z, y, x};
    last = (cnt_r[2] || !ax_r.two) && (cnt_r[1] || !ay_r.two) && (cnt_r[0] || !az_r.two);
  end

  function automatic logic [2:0] next_cnt(input logic [2:0] c, input axis_t x,
                                          input axis_t y, input axis_t z);
    logic [2:0] n;
    n = c;
    if (z.two && !c[0])      n = {c[2], c[1], 1'b1};
    else if (y.two && !c[1]) n = {c[2], 1'b1, 1'b0};
    else                     n = {1'b1, 2'b00};
    return n;
  endfunction

  // Next state.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    clr_nxt   = clr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (ADDR_BITS+1)'(CELLS-1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: if (accept) begin
        cnt_nxt   = 3'd0;
        state_nxt = (in_data.req_type == REQ_READ) ? ST_RREAD
                  : (vel_en_r ? ST_MUL1 : ST_RD);
      end
      ST_MUL1:  if (vdone) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_WR;
      ST_WR: begin
        if (last) state_nxt = ST_IDLE;
        else begin
          cnt_nxt   = next_cnt(cnt_r, ax_r, ay_r, az_r);
          state_nxt = ST_RD;
        end
      end
      ST_RREAD: state_nxt = ST_RWAIT;
      ST_RWAIT: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy      = (state_r != ST_IDLE);
    vgo       = (state_r == ST_IDLE) && accept && in_data.req_type == REQ_DEPOSIT && vel_en_r;
    out_valid = (state_r == ST_RWAIT);
    out_data.density_sum = oor_r ? '0 : rd_d_r;
    out_data.vel_x_sum   = oor_r ? '0 : rd_x_r;
    out_data.vel_y_sum   = oor_r ? '0 : rd_y_r;
    out_data.vel_z_sum   = oor_r ? '0 : rd_z_r;
  end

  function automatic logic [ACC_WIDTH-1:0] sadd(input logic signed [ACC_WIDTH-1:0] s,
                                                input logic signed [ACC_WIDTH-1:0] d);
    logic signed [ACC_WIDTH:0] t;
    t = {s[ACC_WIDTH-1], s} + {d[ACC_WIDTH-1], d};
    if (t > (ACC_WIDTH+1)'(SMAX))         return SMAX;
    else if (t < $signed({1'b1, SMIN}))   return SMIN;
    return t[ACC_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      cnt_r    <= '0;
      weight_r <= '0;
      vel_en_r <= 1'b0;
      disp_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_CELL_WEIGHT: weight_r <= cfg_data;
          REG_VEL_ENABLE:  vel_en_r <= cfg_data[0];
          REG_DISPERSION:  disp_r   <= cfg_data[0];
          default: ;
        endcase
      end
    end
    if (accept) begin
      item_r <= in_data;
      ax_r   <= axis_cells(in_data.pos_x);
      ay_r   <= axis_cells(in_data.pos_y);
      az_r   <= axis_cells(in_data.pos_z);
      oor_r  <= ({1'b0, in_data.cell_index} >= 19'(CELLS));
    end
    if (state_r == ST_RD || state_r == ST_RREAD) begin
      rd_d_r <= mem_d[addr];
      rd_x_r <= mem_x[addr];
      rd_y_r <= mem_y[addr];
      rd_z_r <= mem_z[addr];
    end
    if (state_r == ST_ACC) begin
      wd_d_r <= (rd_d_r > DMAX - ACC_WIDTH'(weight_r)) ? DMAX : rd_d_r + ACC_WIDTH'(weight_r);
      wd_x_r <= vel_en_r ? sadd(rd_x_r, dv[0]) : rd_x_r;
      wd_y_r <= vel_en_r ? sadd(rd_y_r, dv[1]) : rd_y_r;
      wd_z_r <= vel_en_r ? sadd(rd_z_r, dv[2]) : rd_z_r;
    end
    if (state_r == ST_CLEAR) begin
      mem_d[addr] <= '0;
      mem_x[addr] <= '0;
      mem_y[addr] <= '0;
      mem_z[addr] <= '0;
    end else if (state_r == ST_WR) begin
      mem_d[addr] <= wd_d_r;
      mem_x[addr] <= wd_x_r;
      mem_y[addr] <= wd_y_r;
      mem_z[addr] <= wd_z_r;
    end
  end
endmodule

>>> rtl/core/pgd_checker.sv
// Port-level checker for the particle grid deposit block, with its bind.
module pgd_checker import pgd_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after a transaction");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result without an active transaction");
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("block not idle after a read result");
endmodule

bind particle_grid_deposit pgd_checker u_pgd_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid)
);

>>> test/tb_particle_grid_deposit.sv
// Testbench for particle_grid_deposit: directed and random deposits and reads against a predictor.
module tb_particle_grid_deposit;
  import pgd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The limit below covers the clearing pass after reset and the longest deposit
  // many times over.
  localparam int CYCLE_LIMIT = 2_000_000;
  // Cycles to let a deposit finish after its last transaction before a register write.
  localparam int SETTLE_CYCLES = 80;
  localparam logic signed [63:0] SUM_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] SUM_MIN = -64'sd140737488355328;
  localparam logic [47:0] DENS_MAX = 48'hFFFF_FFFF_FFFF;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  in_item_t                 in_data;
  logic                     out_valid;
  out_item_t                out_data;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  particle_grid_deposit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the block's registers.
  logic [31:0] weight_q;
  logic        vel_on_q;
  logic        disp_on_q;

  // Shadow copy of the four cell stores; cells never touched read as zero.
  logic [47:0]        dens_mem[int];
  logic signed [63:0] vx_mem[int];
  logic signed [63:0] vy_mem[int];
  logic signed [63:0] vz_mem[int];

  // Sums that read transactions have asked for, oldest first.
  out_item_t pending_reads[$];
  // Up to 2000 cells that deposits have touched, so reads can look at them.
  int hot_cells[$];

  int mismatches;
  int cycles;
  int deposits_sent;
  int reads_sent;
  int results_seen;
  int sender_idle_pct;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Global watchdog: a hung block must not hold the run forever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // First covered cell on one axis and whether a second cell is covered too.
  function automatic logic [6:0] axis_span(logic [21:0] p);
    logic [5:0]  ip;
    logic [15:0] fr;
    ip = p[21:16];
    fr = p[15:0];
    if (fr < 16'h8000) return {ip - 6'd1, 1'b1};
    return {ip, fr != 16'h8000};
  endfunction

  // Velocity share deposited into each covered cell for one component.
  function automatic logic signed [63:0] velocity_share(logic signed [23:0] v,
                                                         logic signed [23:0] vx);
    logic [23:0]  mag_v;
    logic [23:0]  mag_x;
    logic [127:0] prod;
    logic [127:0] mag;
    logic         neg;
    mag_v = v[23] ? (24'd0 - v) : v;
    mag_x = vx[23] ? (24'd0 - vx) : vx;
    prod = 128'(weight_q) * 128'(mag_v);
    if (disp_on_q) begin
      mag = (prod * 128'(mag_x)) >> (2 * VEL_FRAC_BITS);
      neg = v[23] ^ vx[23];
    end else begin
      mag = prod >> VEL_FRAC_BITS;
      neg = v[23];
    end
    if (mag == 0) return 64'sd0;
    if (mag > 128'(SUM_MAX)) return neg ? SUM_MIN : SUM_MAX;
    return neg ? -$signed(mag[63:0]) : $signed(mag[63:0]);
  endfunction

  function automatic logic signed [63:0] clamp_add(logic signed [63:0] s,
                                                    logic signed [63:0] d);
    logic signed [63:0] r;
    r = s + d;
    if (r > SUM_MAX) return SUM_MAX;
    if (r < SUM_MIN) return SUM_MIN;
    return r;
  endfunction

  // Apply one accepted deposit to the shadow stores, or queue the sums a read expects.
  task automatic predict_item(in_item_t it);
    logic [6:0]         ax, ay, az;
    logic signed [63:0] dvx, dvy, dvz;
    logic [5:0]         x, y, z;
    logic [48:0]        dsum;
    int                 c;
    out_item_t          r;
    if (it.req_type == REQ_READ) begin
      c = int'(it.cell_index);
      r.density_sum = dens_mem.exists(c) ? dens_mem[c] : '0;
      r.vel_x_sum   = vx_mem.exists(c) ? vx_mem[c][47:0] : '0;
      r.vel_y_sum   = vy_mem.exists(c) ? vy_mem[c][47:0] : '0;
      r.vel_z_sum   = vz_mem.exists(c) ? vz_mem[c][47:0] : '0;
      pending_reads.push_back(r);
      reads_sent++;
      return;
    end
    deposits_sent++;
    ax = axis_span(it.pos_x);
    ay = axis_span(it.pos_y);
    az = axis_span(it.pos_z);
    dvx = 0; dvy = 0; dvz = 0;
    if (vel_on_q) begin
      dvx = velocity_share(it.vel_x, it.vel_x);
      dvy = velocity_share(it.vel_y, it.vel_x);
      dvz = velocity_share(it.vel_z, it.vel_x);
    end
    for (int i = 0; i <= int'(ax[0]); i++) begin
      for (int j = 0; j <= int'(ay[0]); j++) begin
        for (int k = 0; k <= int'(az[0]); k++) begin
          // Six-bit sums wrap around the periodic grid on their own.
          x = ax[6:1] + 6'(i);
          y = ay[6:1] + 6'(j);
          z = az[6:1] + 6'(k);
          c = int'({z, y, x});
          if (!dens_mem.exists(c)) begin
            dens_mem[c] = '0; vx_mem[c] = 0; vy_mem[c] = 0; vz_mem[c] = 0;
            if (hot_cells.size() < 2000) hot_cells.push_back(c);
          end
          dsum = {1'b0, dens_mem[c]} + 49'(weight_q);
          dens_mem[c] = (dsum > 49'(DENS_MAX)) ? DENS_MAX : dsum[47:0];
          if (vel_on_q) begin
            vx_mem[c] = clamp_add(vx_mem[c], dvx);
            vy_mem[c] = clamp_add(vy_mem[c], dvy);
            vz_mem[c] = clamp_add(vz_mem[c], dvz);
          end
        end
      end
    end
  endtask

  // Send one transaction after an optional idle gap; start stays high on return so
  // that a following call can keep it high without a glitch.
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    predict_item(it);
  endtask

  // Let every outstanding transaction finish, including deposits that give no result.
  task automatic drain_block();
    start <= 1'b0;
    while (pending_reads.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CELL_WEIGHT: weight_q  = val;
      REG_VEL_ENABLE:  vel_on_q  = val[0];
      REG_DISPERSION:  disp_on_q = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] w, logic ve, logic dm);
    drain_block();
    write_reg(REG_CELL_WEIGHT, w);
    write_reg(REG_VEL_ENABLE, {31'(0), ve});
    write_reg(REG_DISPERSION, {31'(0), dm});
  endtask

  function automatic logic [21:0] make_pos(int ip, logic [15:0] fr);
    return {6'(ip), fr};
  endfunction

  function automatic in_item_t deposit_item(logic [21:0] px, logic [21:0] py, logic [21:0] pz,
                                            logic [23:0] vx, logic [23:0] vy, logic [23:0] vz);
    in_item_t it;
    it = '{default: '0};
    it.req_type = REQ_DEPOSIT;
    it.pos_x = px; it.pos_y = py; it.pos_z = pz;
    it.vel_x = vx; it.vel_y = vy; it.vel_z = vz;
    it.cell_index = 18'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_item(int c);
    in_item_t it;
    it = '{default: '0};
    it.pos_x = 22'($urandom); it.pos_y = 22'($urandom); it.pos_z = 22'($urandom);
    it.vel_x = 24'($urandom); it.vel_y = 24'($urandom); it.vel_z = 24'($urandom);
    it.req_type   = REQ_READ;
    it.cell_index = 18'(c);
    return it;
  endfunction

  // A coordinate that mostly lands in a small corner region, including the wrap edge.
  function automatic logic [21:0] clustered_pos();
    int          ip;
    logic [15:0] fr;
    case ($urandom_range(4))
      0: ip = 0;
      1: ip = 63;
      2: ip = 1;
      default: ip = $urandom_range(3);
    endcase
    case ($urandom_range(5))
      0: fr = 16'h8000;
      1: fr = 16'h0000;
      2: fr = 16'h7FFF;
      3: fr = 16'hFFFF;
      default: fr = 16'($urandom);
    endcase
    return make_pos(ip, fr);
  endfunction

  function automatic logic [23:0] random_vel();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(16));
      default: return 24'($urandom);
    endcase
  endfunction

  // Every result the block shows is taken at the edge that ends its cycle.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", out_data);
      end else begin
        want = pending_reads.pop_front();
        if (out_data.density_sum !== want.density_sum ||
            out_data.vel_x_sum !== want.vel_x_sum ||
            out_data.vel_y_sum !== want.vel_y_sum ||
            out_data.vel_z_sum !== want.vel_z_sum) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p got %p", want, out_data);
        end
      end
    end
  end

  // Extremes of position, velocity and weight, the half-cell case and the grid wrap.
  task automatic test_directed();
    set_config(32'h0001_0000, 1'b1, 1'b0);
    send_item(deposit_item(make_pos(0, 16'h0000), make_pos(0, 16'h0000),
                           make_pos(0, 16'h0000), 24'h7FFFFF, 24'h800000, 24'h000000));
    send_item(deposit_item(make_pos(0, 16'h8000), make_pos(0, 16'h8000),
                           make_pos(0, 16'h8000), 24'h001000, 24'hFFF000, 24'h000001));
    send_item(deposit_item(22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF,
                           24'h800000, 24'h7FFFFF, 24'hFFFFFF));
    send_item(read_item(0));
    send_item(read_item(63));
    send_item(read_item(63 + 63 * 64 + 63 * 4096));
    send_item(read_item(262143 - 64));
    send_item(read_item(18'h3FFFF));
    set_config(32'hFFFF_FFFF, 1'b1, 1'b1);
    // Full-scale dispersion deposits saturate every velocity sum; the third pulls the y sum back out of saturation.
    send_item(deposit_item(make_pos(5, 16'h8000), make_pos(5, 16'h8000),
                           make_pos(5, 16'h8000), 24'h7FFFFF, 24'h7FFFFF, 24'h800000));
    send_item(deposit_item(make_pos(5, 16'h8000), make_pos(5, 16'h8000),
                           make_pos(5, 16'h8000), 24'h7FFFFF, 24'h7FFFFF, 24'h800000));
    send_item(deposit_item(make_pos(5, 16'h8000), make_pos(5, 16'h8000),
                           make_pos(5, 16'h8000), 24'h800000, 24'h7FFFFF, 24'h000000));
    send_item(read_item(5 + 5 * 64 + 5 * 4096));
    set_config(32'hFFFF_FFFF, 1'b0, 1'b1);
    send_item(deposit_item(make_pos(5, 16'h8000), make_pos(5, 16'h8000),
                           make_pos(5, 16'h8000), 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    send_item(read_item(5 + 5 * 64 + 5 * 4096));
    set_config(32'h0000_0000, 1'b1, 1'b0);
    send_item(deposit_item(make_pos(7, 16'hFFFF), make_pos(7, 16'h8001),
                           make_pos(7, 16'h7FFF), 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    send_item(read_item(7 + 7 * 64 + 7 * 4096));
    send_item(read_item(6 + 7 * 64 + 7 * 4096));
  endtask

  // Mostly clustered deposits with reads of touched cells, plus fully random noise.
  task automatic test_random(int count);
    in_item_t it;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3:
          it = deposit_item(clustered_pos(), clustered_pos(), clustered_pos(),
                            random_vel(), random_vel(), random_vel());
        4:
          it = deposit_item(22'($urandom), 22'($urandom), 22'($urandom),
                            24'($urandom), 24'($urandom), 24'($urandom));
        5:
          it = read_item($urandom_range(18'h3FFFF));
        default:
          it = read_item(hot_cells.size() ? hot_cells[$urandom_range(hot_cells.size() - 1)]
                                          : 0);
      endcase
      send_item(it);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    mismatches = 0;
    deposits_sent = 0;
    reads_sent = 0;
    results_seen = 0;
    sender_idle_pct = 0;
    weight_q = '0;
    vel_on_q = 1'b0;
    disp_on_q = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();

    sender_idle_pct = 22;
    set_config($urandom, 1'b1, 1'b0);
    test_random(70);
    set_config(32'h0000_0001, 1'b1, 1'b1);
    test_random(60);

    sender_idle_pct = 47;
    set_config(32'hFFFF_FFFF, 1'b1, 1'b1);
    test_random(70);
    set_config($urandom_range(32'h0004_0000), 1'b0, 1'b0);
    test_random(60);

    sender_idle_pct = 0;
    set_config($urandom, 1'b1, 1'b1);
    test_random(70);
    set_config(32'h0000_0000, 1'b0, 1'b1);
    test_random(70);

    drain_block();
    $display("covered %0d deposit and %0d read transactions, %0d results checked",
             deposits_sent, reads_sent, results_seen);
    $display("register settings included zero and full-scale weight, plain and dispersion");
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
